FILE: design/cis_pkg.sv
// cis_pkg: shared widths, pipeline depths and the arctangent table
// for the circle-in-sector test; no dependencies
package cis_pkg;

    // geometry datapath widths after the coordinate reduction
    localparam int CIS_U_W    = 24;   // |dx|, |dy|
    localparam int CIS_R_W    = 23;   // radius
    localparam int CIS_SQ_W   = 48;   // one square of a coordinate delta
    localparam int CIS_RSQ_W  = 46;   // radius square
    localparam int CIS_D_W    = 49;   // dx^2 + dy^2
    localparam int CIS_V_W    = 51;   // 4D - R^2
    localparam int CIS_REM_W  = 52;   // square root remainder
    localparam int CIS_ROOT_W = 26;   // square root result
    localparam int CIS_A_W    = 52;   // 2D - R^2, signed
    localparam int CIS_H_W    = 49;   // R * root

    // arctangent unit
    localparam int CIS_CW       = 56; // rotation datapath, signed
    localparam int CIS_STEPS    = 30;
    localparam int CIS_NORM_BIT = 40; // inputs scaled up until this bit is reached
    localparam int CIS_CHUNKS   = 5;  // 8-bit groups below CIS_NORM_BIT
    localparam int CIS_ATAN_LAT = CIS_STEPS + 5;

    typedef logic [31:0] t_ang32;

    localparam t_ang32 CIS_ATAN_TAB [CIS_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    localparam t_ang32 CIS_ACC_HALF_TURN = 32'h80000000;

endpackage

FILE: design/cis_atan2.sv
// cis_atan2: pipelined vectoring arctangent (sign fold, scale-up, rotation steps,
// rounding to a binary angle); depends on cis_pkg
module cis_atan2 #(
    parameter int ANGLE_BITS = 16,
    parameter int IN_W       = 52
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [IN_W-1:0]  i_y,
    input  logic signed [IN_W-1:0]  i_x,
    output logic [ANGLE_BITS-1:0]   o_angle
);

    localparam int W  = cis_pkg::CIS_CW;
    localparam int NS = cis_pkg::CIS_STEPS;
    localparam int NB = cis_pkg::CIS_NORM_BIT;
    localparam int NC = cis_pkg::CIS_CHUNKS;

    // fold stage
    logic signed [W-1:0] r0_x, r0_y;
    cis_pkg::t_ang32     r0_acc;
    logic                r0_z;
    // scan stage
    logic signed [W-1:0] r1_x, r1_y;
    cis_pkg::t_ang32     r1_acc;
    logic                r1_z, r1_big;
    logic [NC-1:0]       r1_nz;
    logic [2:0]          r1_pos [NC];
    // shift amount stage
    logic signed [W-1:0] r2_x, r2_y;
    cis_pkg::t_ang32     r2_acc;
    logic                r2_z;
    logic [5:0]          r2_sh;
    // rotation steps, index 0 is the scaled vector
    logic signed [W-1:0] r_it_x [NS+1];
    logic signed [W-1:0] r_it_y [NS+1];
    cis_pkg::t_ang32     r_it_acc [NS+1];
    logic                r_it_z [NS+1];
    logic [ANGLE_BITS-1:0] r_ang;

    logic signed [W-1:0] n0_xs, n0_ys, n1_my;
    logic [W-1:0]        n1_m;
    logic [NC-1:0]       n1_nz;
    logic [2:0]          n1_pos [NC];
    logic [5:0]          n2_sh;
    logic signed [W-1:0] n_it_x [NS+1];
    logic signed [W-1:0] n_it_y [NS+1];
    cis_pkg::t_ang32     n_it_acc [NS+1];
    cis_pkg::t_ang32     n_rnd;

    assign n0_xs = W'(i_x);
    assign n0_ys = W'(i_y);
    assign n1_my = r0_y[W-1] ? -r0_y : r0_y;
    assign n1_m  = r0_x | n1_my;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n1_nz[c]  = |n1_m[8*c +: 8];
            n1_pos[c] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (n1_m[8*c + b]) begin
                    n1_pos[c] = 3'(b);
                end
            end
        end
    end

    // distance of the leading one from the scale-up target bit
    always_comb begin
        n2_sh = 6'd0;
        for (int c = 0; c < NC; c++) begin
            if (r1_nz[c]) begin
                n2_sh = 6'(NB - (8*c + int'(r1_pos[c])));
            end
        end
        if (r1_big || r1_z) begin
            n2_sh = 6'd0;
        end
    end

    always_comb begin
        n_it_x[0]   = r_it_x[0];
        n_it_y[0]   = r_it_y[0];
        n_it_acc[0] = r_it_acc[0];
        for (int i = 0; i < NS; i++) begin
            if (!r_it_y[i][W-1] && (r_it_y[i] != '0)) begin
                n_it_x[i+1]   = r_it_x[i] + (r_it_y[i] >>> i);
                n_it_y[i+1]   = r_it_y[i] - (r_it_x[i] >>> i);
                n_it_acc[i+1] = r_it_acc[i] + cis_pkg::CIS_ATAN_TAB[i];
            end else begin
                n_it_x[i+1]   = r_it_x[i] - (r_it_y[i] >>> i);
                n_it_y[i+1]   = r_it_y[i] + (r_it_x[i] >>> i);
                n_it_acc[i+1] = r_it_acc[i] - cis_pkg::CIS_ATAN_TAB[i];
            end
        end
    end

    assign n_rnd = r_it_acc[NS] + (cis_pkg::t_ang32'(1) << (31 - ANGLE_BITS));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_x   <= n0_xs[W-1] ? -n0_xs : n0_xs;
            r0_y   <= n0_xs[W-1] ? -n0_ys : n0_ys;
            r0_acc <= n0_xs[W-1] ? cis_pkg::CIS_ACC_HALF_TURN : '0;
            r0_z   <= (n0_xs == '0) && (n0_ys == '0);

            r1_x   <= r0_x;
            r1_y   <= r0_y;
            r1_acc <= r0_acc;
            r1_z   <= r0_z;
            r1_big <= |n1_m[W-1:NB];
            r1_nz  <= n1_nz;
            r1_pos <= n1_pos;

            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_acc <= r1_acc;
            r2_z   <= r1_z;
            r2_sh  <= n2_sh;

            r_it_x[0]   <= r2_x <<< r2_sh;
            r_it_y[0]   <= r2_y <<< r2_sh;
            r_it_acc[0] <= r2_acc;
            r_it_z[0]   <= r2_z;
            for (int i = 1; i <= NS; i++) begin
                r_it_x[i]   <= n_it_x[i];
                r_it_y[i]   <= n_it_y[i];
                r_it_acc[i] <= n_it_acc[i];
                r_it_z[i]   <= r_it_z[i-1];
            end

            r_ang <= r_it_z[NS] ? '0 : n_rnd[31 -: ANGLE_BITS];
        end
    end

    assign o_angle = r_ang;

endmodule

FILE: design/circle_in_sector_test_top.sv
// circle_in_sector_test_top: circle versus circular sector overlap test, deep pipeline
// depends on cis_pkg and cis_atan2
//
// usage:
//   slave stream (i_s_*) takes one request per test: apex, facing yaw, circle centre and
//   radius packed in tdata. master stream (o_m_*) returns one byte whose bit 0 is the
//   inside flag. the sector opening must be written on the cfg channel (always
//   ready) only while no request is in flight; the block itself does not enforce this.
// stages: 5 geometry stages, 26 square root digit stages, one multiply stage,
//   35 arctangent stages and 2 compare stages lie between request accept and result valid
// throughput: one request per cycle while the output is not stalled; every stage is a
//   register stage with its own valid bit, so bubbles move through at full rate
// stall: all stages advance together when the output register is empty or taken;
//   while the receiver holds off a waiting result the pipeline freezes and i_s_tready
//   stays low, nothing is dropped or repeated
// reset: i_rst_n low clears every valid bit and sets the opening to zero
module circle_in_sector_test_top #(
    parameter int ANGLE_BITS = 16,
    parameter int COORD_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // origin_x, origin_y, facing_yaw, circle_x, circle_y, circle_radius, zero pad
    input  logic [((5*COORD_BITS+ANGLE_BITS-1+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // inside_res, zero pad
    output logic [7:0] o_m_tdata,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [ANGLE_BITS-1:0] i_cfg_data
);

    localparam int C  = COORD_BITS;
    localparam int A  = ANGLE_BITS;
    localparam int HALF_SHIFT = (C > 24) ? C - 24 : 0;
    localparam int UW = cis_pkg::CIS_U_W;
    localparam int RW = cis_pkg::CIS_R_W;
    localparam int NQ = cis_pkg::CIS_ROOT_W;
    localparam int AL = cis_pkg::CIS_ATAN_LAT;
    localparam int CW = cis_pkg::CIS_CW;

    localparam logic [A-1:0] ANG_HALF    = A'(1) << (A - 1);
    localparam logic [A-1:0] ANG_QUARTER = A'(1) << (A - 2);

    typedef struct packed {
        logic signed [C:0] dx;
        logic signed [C:0] dy;
        logic [A-1:0]      fac;
    } t_side;

    function automatic logic [A-1:0] f_wrap(input logic [A-1:0] v);
        f_wrap = (v > ANG_HALF) ? (A'(0) - v) : v;
    endfunction

    logic en;
    logic [A-1:0] r_open;

    // field split
    logic signed [C-1:0] n_ox, n_oy, n_cx, n_cy;
    logic [A-1:0]        n_fac;
    logic [C-2:0]        n_rad;
    assign n_ox  = $signed(i_s_tdata[0 +: C]);
    assign n_oy  = $signed(i_s_tdata[C +: C]);
    assign n_fac = i_s_tdata[2*C +: A];
    assign n_cx  = $signed(i_s_tdata[2*C+A +: C]);
    assign n_cy  = $signed(i_s_tdata[3*C+A +: C]);
    assign n_rad = i_s_tdata[4*C+A +: C-1];

    // geometry stages
    logic        r1_vld, r2_vld, r3_vld, r4_vld;
    t_side       r1_sd, r2_sd, r3_sd, r4_sd;
    logic [C-2:0] r1_rad;
    logic [UW-1:0] r2_ux, r2_uy;
    logic [RW-1:0] r2_r, r3_r, r4_r;
    logic [cis_pkg::CIS_SQ_W-1:0]  r3_xx, r3_yy;
    logic [cis_pkg::CIS_RSQ_W-1:0] r3_rsq, r4_rsq;
    logic [cis_pkg::CIS_D_W-1:0]   r4_dsq;

    logic [C:0]    n_mx, n_my;
    logic [CW-1:0] n_ux, n_uy, n_ur;
    logic [cis_pkg::CIS_V_W-1:0] n_d4;

    assign n_mx = r1_sd.dx[C] ? -r1_sd.dx : r1_sd.dx;
    assign n_my = r1_sd.dy[C] ? -r1_sd.dy : r1_sd.dy;
    assign n_ux = CW'(n_mx[C-1:0]) >> HALF_SHIFT;
    assign n_uy = CW'(n_my[C-1:0]) >> HALF_SHIFT;
    assign n_ur = CW'(r1_rad) >> HALF_SHIFT;
    assign n_d4 = {r4_dsq, 2'b00};

    // square root digit stages, index 0 holds 4D - R^2
    logic                          r_sq_vld  [NQ+1];
    t_side                         r_sq_sd   [NQ+1];
    logic [RW-1:0]                 r_sq_r    [NQ+1];
    logic signed [cis_pkg::CIS_A_W-1:0] r_sq_a [NQ+1];
    logic                          r_sq_dg   [NQ+1];
    logic [cis_pkg::CIS_REM_W-1:0] r_sq_rem  [NQ+1];
    logic [NQ-1:0]                 r_sq_root [NQ+1];

    logic [cis_pkg::CIS_REM_W-1:0] n_sq_trial [NQ+1];
    logic [cis_pkg::CIS_REM_W-1:0] n_sq_rem   [NQ+1];
    logic [NQ-1:0]                 n_sq_root  [NQ+1];

    always_comb begin
        n_sq_trial[0] = '0;
        n_sq_rem[0]   = r_sq_rem[0];
        n_sq_root[0]  = r_sq_root[0];
        for (int j = 1; j <= NQ; j++) begin
            // (root + 2^k)^2 - root^2 for the digit k of this stage
            n_sq_trial[j] = (cis_pkg::CIS_REM_W'(r_sq_root[j-1]) << (NQ + 1 - j))
                          | (cis_pkg::CIS_REM_W'(1) << (2 * (NQ - j)));
            if (r_sq_rem[j-1] >= n_sq_trial[j]) begin
                n_sq_rem[j]  = r_sq_rem[j-1] - n_sq_trial[j];
                n_sq_root[j] = r_sq_root[j-1] | (NQ'(1) << (NQ - j));
            end else begin
                n_sq_rem[j]  = r_sq_rem[j-1];
                n_sq_root[j] = r_sq_root[j-1];
            end
        end
    end

    // product stage feeding both arctangent units
    logic                               r5_vld, r5_dg;
    t_side                              r5_sd;
    logic signed [cis_pkg::CIS_A_W-1:0] r5_a;
    logic [cis_pkg::CIS_H_W-1:0]        r5_h;

    // side line along the arctangent units
    logic         r_at_vld [AL];
    logic         r_at_dg  [AL];
    logic [A-1:0] r_at_fac [AL];

    logic [A-1:0] w_half, w_yaw;

    cis_atan2 #(
        .ANGLE_BITS(A),
        .IN_W      (cis_pkg::CIS_A_W)
    ) u_atan_half (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    ($signed(cis_pkg::CIS_A_W'(r5_h))),
        .i_x    (r5_a),
        .o_angle(w_half)
    );

    cis_atan2 #(
        .ANGLE_BITS(A),
        .IN_W      (C + 1)
    ) u_atan_yaw (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (r5_sd.dy),
        .i_x    (r5_sd.dx),
        .o_angle(w_yaw)
    );

    // angle distance stage
    logic         r_g_vld, r_g_dg;
    logic [A-1:0] r_g_left, r_g_right, r_g_marg;
    logic [A-1:0] n_my_yaw, n_dl, n_dr;

    assign n_my_yaw = r_at_fac[AL-1] - ANG_QUARTER;
    assign n_dl     = w_yaw - n_my_yaw;
    assign n_dr     = n_dl - r_open;

    // decision
    logic r_out_vld, r_out_ins;
    logic [A+1:0] n_l2, n_r2, n_lim_n;
    logic signed [A+2:0] n_lim_w;
    logic n_ins;

    always_comb begin
        n_l2    = (A+2)'({r_g_left, 1'b0});
        n_r2    = (A+2)'({r_g_right, 1'b0});
        n_lim_n = (A+2)'({r_open, 1'b0}) + (A+2)'(r_g_marg);
        n_lim_w = $signed((A+3)'({A'(0) - r_open, 1'b0})) - $signed((A+3)'(r_g_marg));
        if (r_g_dg) begin
            n_ins = 1'b1;
        end else if (r_open <= ANG_HALF) begin
            n_ins = (n_l2 <= n_lim_n) && (n_r2 <= n_lim_n);
        end else begin
            n_ins = ($signed((A+3)'(n_l2)) >= n_lim_w) || ($signed((A+3)'(n_r2)) >= n_lim_w);
        end
    end

    assign en          = !r_out_vld || i_m_tready;
    assign o_s_tready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = {7'd0, r_out_ins};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (i_cfg_valid) begin
            r_open <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r_g_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int j = 0; j <= NQ; j++) begin
                r_sq_vld[j] <= 1'b0;
            end
            for (int j = 0; j < AL; j++) begin
                r_at_vld[j] <= 1'b0;
            end
        end else if (en) begin
            r1_vld <= i_s_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r_sq_vld[0] <= r4_vld;
            for (int j = 1; j <= NQ; j++) begin
                r_sq_vld[j] <= r_sq_vld[j-1];
            end
            r5_vld <= r_sq_vld[NQ];
            r_at_vld[0] <= r5_vld;
            for (int j = 1; j < AL; j++) begin
                r_at_vld[j] <= r_at_vld[j-1];
            end
            r_g_vld   <= r_at_vld[AL-1];
            r_out_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sd.dx  <= {n_cx[C-1], n_cx} - {n_ox[C-1], n_ox};
            r1_sd.dy  <= {n_cy[C-1], n_cy} - {n_oy[C-1], n_oy};
            r1_sd.fac <= n_fac;
            r1_rad    <= n_rad;

            r2_sd <= r1_sd;
            r2_ux <= n_ux[UW-1:0];
            r2_uy <= n_uy[UW-1:0];
            r2_r  <= n_ur[RW-1:0];

            r3_sd  <= r2_sd;
            r3_r   <= r2_r;
            r3_xx  <= r2_ux * r2_ux;
            r3_yy  <= r2_uy * r2_uy;
            r3_rsq <= r2_r * r2_r;

            r4_sd  <= r3_sd;
            r4_r   <= r3_r;
            r4_rsq <= r3_rsq;
            r4_dsq <= cis_pkg::CIS_D_W'(r3_xx) + cis_pkg::CIS_D_W'(r3_yy);

            // circle covering the apex is decided here
            r_sq_sd[0]   <= r4_sd;
            r_sq_r[0]    <= r4_r;
            r_sq_dg[0]   <= (cis_pkg::CIS_V_W'(r4_rsq) > n_d4)
                          || ((r4_dsq == '0) && (r4_r == '0));
            r_sq_a[0]    <= $signed(cis_pkg::CIS_A_W'({r4_dsq, 1'b0}))
                          - $signed(cis_pkg::CIS_A_W'(r4_rsq));
            r_sq_rem[0]  <= cis_pkg::CIS_REM_W'(n_d4 - cis_pkg::CIS_V_W'(r4_rsq));
            r_sq_root[0] <= '0;
            for (int j = 1; j <= NQ; j++) begin
                r_sq_sd[j]   <= r_sq_sd[j-1];
                r_sq_r[j]    <= r_sq_r[j-1];
                r_sq_dg[j]   <= r_sq_dg[j-1];
                r_sq_a[j]    <= r_sq_a[j-1];
                r_sq_rem[j]  <= n_sq_rem[j];
                r_sq_root[j] <= n_sq_root[j];
            end

            r5_sd <= r_sq_sd[NQ];
            r5_dg <= r_sq_dg[NQ];
            r5_a  <= r_sq_a[NQ];
            r5_h  <= cis_pkg::CIS_H_W'(r_sq_r[NQ]) * cis_pkg::CIS_H_W'(r_sq_root[NQ]);

            r_at_dg[0]  <= r5_dg;
            r_at_fac[0] <= r5_sd.fac;
            for (int j = 1; j < AL; j++) begin
                r_at_dg[j]  <= r_at_dg[j-1];
                r_at_fac[j] <= r_at_fac[j-1];
            end

            r_g_dg    <= r_at_dg[AL-1];
            r_g_left  <= f_wrap(n_dl);
            r_g_right <= f_wrap(n_dr);
            r_g_marg  <= f_wrap(w_half << 1);

            r_out_ins <= n_ins;
        end
    end

    // a circle over the apex always reports inside
    a_degen_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_g_vld && r_g_dg) |=> (r_out_vld && r_out_ins))
        else $error("covered apex did not report inside");

    // a held result freezes the front of the pipeline
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> ($stable(r1_vld) && $stable(r_sq_vld[0])))
        else $error("pipeline moved during output stall");

    // an accepted request enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r1_vld)
        else $error("accepted request lost at entry");

endmodule
